// ===== design/ppkd_pkg.sv =====
// shared types and constants for the parallel port keyboard/display block
`default_nettype none

package ppkd_pkg;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_KEY   = 2'd2,
    REQ_IDLE  = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    SEL_A_DATA = 2'd0,
    SEL_A_CTRL = 2'd1,
    SEL_B_DATA = 2'd2,
    SEL_B_CTRL = 2'd3
  } reg_sel_t;

  localparam int unsigned CTRL_ROUTE_BIT = 2;
  localparam logic [7:0]  CODE_MASK      = 8'h7F;
  localparam logic [7:0]  STROBE         = 8'h80;

  typedef struct packed {
    logic [7:0] read_data;
    logic       display_valid;
    logic [7:0] display_byte;
    logic       key_ready;
  } result_t;

endpackage

`default_nettype wire

// ===== design/ppkd_regfile.sv =====
// port registers, bus decode and keyboard load for the parallel port block
`default_nettype none

module ppkd_regfile (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              commit,
  input  wire ppkd_pkg::req_type_t req_type,
  input  wire ppkd_pkg::reg_sel_t  reg_sel,
  input  wire logic [7:0]        write_data,
  input  wire logic [6:0]        kbd_char,
  output ppkd_pkg::result_t      result
);

  logic [7:0] port_a_value_r, port_a_value_nxt;
  logic [7:0] port_b_value_r, port_b_value_nxt;
  logic [7:0] port_a_dir_r,   port_a_dir_nxt;
  logic [7:0] port_b_dir_r,   port_b_dir_nxt;
  logic [7:0] port_a_ctrl_r,  port_a_ctrl_nxt;
  logic [7:0] port_b_ctrl_r,  port_b_ctrl_nxt;

  logic a_route, b_route;

  assign a_route = port_a_ctrl_r[ppkd_pkg::CTRL_ROUTE_BIT];
  assign b_route = port_b_ctrl_r[ppkd_pkg::CTRL_ROUTE_BIT];

  always_comb begin
    port_a_value_nxt = port_a_value_r;
    port_b_value_nxt = port_b_value_r;
    port_a_dir_nxt   = port_a_dir_r;
    port_b_dir_nxt   = port_b_dir_r;
    port_a_ctrl_nxt  = port_a_ctrl_r;
    port_b_ctrl_nxt  = port_b_ctrl_r;
    result           = '0;

    unique case (req_type)
      ppkd_pkg::REQ_READ: begin
        unique case (reg_sel)
          ppkd_pkg::SEL_A_DATA: begin
            if (a_route) begin
              result.read_data = port_a_value_r;
              // reading the key byte clears the strobe
              port_a_value_nxt = port_a_value_r & ppkd_pkg::CODE_MASK;
            end else begin
              result.read_data = port_a_dir_r;
            end
          end
          ppkd_pkg::SEL_A_CTRL: result.read_data = port_a_ctrl_r;
          ppkd_pkg::SEL_B_DATA: result.read_data = b_route ? port_b_value_r : port_b_dir_r;
          ppkd_pkg::SEL_B_CTRL: result.read_data = port_b_ctrl_r;
          default:              result.read_data = '0;
        endcase
      end
      ppkd_pkg::REQ_WRITE: begin
        unique case (reg_sel)
          ppkd_pkg::SEL_A_DATA: begin
            if (a_route) port_a_value_nxt = write_data;
            else         port_a_dir_nxt   = write_data;
          end
          ppkd_pkg::SEL_A_CTRL: port_a_ctrl_nxt = write_data;
          ppkd_pkg::SEL_B_DATA: begin
            if (b_route) begin
              port_b_value_nxt     = write_data;
              result.display_valid = 1'b1;
              result.display_byte  = write_data;
            end else begin
              port_b_dir_nxt = write_data;
            end
          end
          ppkd_pkg::SEL_B_CTRL: port_b_ctrl_nxt = write_data;
          default:              port_b_ctrl_nxt = port_b_ctrl_r;
        endcase
      end
      ppkd_pkg::REQ_KEY:  port_a_value_nxt = ppkd_pkg::STROBE | {1'b0, kbd_char};
      ppkd_pkg::REQ_IDLE: port_a_value_nxt = port_a_value_r;
      default:            port_a_value_nxt = port_a_value_r;
    endcase

    result.key_ready = port_a_value_nxt[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      port_a_value_r <= '0;
      port_b_value_r <= '0;
      port_a_dir_r   <= '0;
      port_b_dir_r   <= '0;
      port_a_ctrl_r  <= '0;
      port_b_ctrl_r  <= '0;
    end else if (commit) begin
      port_a_value_r <= port_a_value_nxt;
      port_b_value_r <= port_b_value_nxt;
      port_a_dir_r   <= port_a_dir_nxt;
      port_b_dir_r   <= port_b_dir_nxt;
      port_a_ctrl_r  <= port_a_ctrl_nxt;
      port_b_ctrl_r  <= port_b_ctrl_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/parallel_port_keyboard_display_top.sv =====
// from input accept to result valid a word passes the input register, then the result register
// throughput: one word per cycle while out_ready stays high
// the register file is updated as a word moves from the input to the result register
// in_ready holds low only while both registers are full and out_ready is low
// reset (synchronous, rst_n low) clears all port, direction and control registers
`default_nettype none

module parallel_port_keyboard_display_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [1:0] in_reg_sel,
  input  wire logic [7:0] in_write_data,
  input  wire logic [6:0] in_kbd_char,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_read_data,
  output logic            out_display_valid,
  output logic [7:0]      out_display_byte,
  output logic            out_key_ready
);

  logic       s1_valid_r;
  logic [1:0] s1_req_type_r;
  logic [1:0] s1_reg_sel_r;
  logic [7:0] s1_write_data_r;
  logic [6:0] s1_kbd_char_r;

  logic              out_valid_r;
  ppkd_pkg::result_t out_result_r;
  ppkd_pkg::result_t result;

  logic s1_advance;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req_type_r   <= in_req_type;
      s1_reg_sel_r    <= in_reg_sel;
      s1_write_data_r <= in_write_data;
      s1_kbd_char_r   <= in_kbd_char;
    end
  end

  ppkd_regfile u_regfile (
    .clk        (clk),
    .rst_n      (rst_n),
    .commit     (s1_advance),
    .req_type   (ppkd_pkg::req_type_t'(s1_req_type_r)),
    .reg_sel    (ppkd_pkg::reg_sel_t'(s1_reg_sel_r)),
    .write_data (s1_write_data_r),
    .kbd_char   (s1_kbd_char_r),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_result_r <= result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_result_r.read_data;
  assign out_display_valid = out_result_r.display_valid;
  assign out_display_byte  = out_result_r.display_byte;
  assign out_key_ready     = out_result_r.key_ready;

endmodule

`default_nettype wire

// ===== verif/parallel_port_keyboard_display_top_test.sv =====
// self-checking testbench for the parallel port keyboard/display block
`timescale 1ns / 100ps

module parallel_port_keyboard_display_top_test;

  // mirror of the port registers plus the queue of results still owed by the block
  class port_scoreboard;
    logic [7:0] a_value, b_value, a_dir, b_dir, a_ctrl, b_ctrl;
    ppkd_pkg::result_t owed_q[$];
    int errors;

    function new();
      a_value = '0;
      b_value = '0;
      a_dir = '0;
      b_dir = '0;
      a_ctrl = '0;
      b_ctrl = '0;
      errors = 0;
    endfunction

    function void note_request(ppkd_pkg::req_type_t req, ppkd_pkg::reg_sel_t sel,
                               logic [7:0] wd, logic [6:0] kc);
      ppkd_pkg::result_t r;
      r = '0;
      case (req)
        ppkd_pkg::REQ_READ: begin
          case (sel)
            ppkd_pkg::SEL_A_DATA: begin
              if (a_ctrl[ppkd_pkg::CTRL_ROUTE_BIT]) begin
                r.read_data = a_value;
                a_value = a_value & ppkd_pkg::CODE_MASK;
              end else begin
                r.read_data = a_dir;
              end
            end
            ppkd_pkg::SEL_A_CTRL: r.read_data = a_ctrl;
            ppkd_pkg::SEL_B_DATA:
              r.read_data = b_ctrl[ppkd_pkg::CTRL_ROUTE_BIT] ? b_value : b_dir;
            default: r.read_data = b_ctrl;
          endcase
        end
        ppkd_pkg::REQ_WRITE: begin
          case (sel)
            ppkd_pkg::SEL_A_DATA: begin
              if (a_ctrl[ppkd_pkg::CTRL_ROUTE_BIT]) a_value = wd;
              else a_dir = wd;
            end
            ppkd_pkg::SEL_A_CTRL: a_ctrl = wd;
            ppkd_pkg::SEL_B_DATA: begin
              if (b_ctrl[ppkd_pkg::CTRL_ROUTE_BIT]) begin
                b_value = wd;
                r.display_valid = 1'b1;
                r.display_byte = wd;
              end else begin
                b_dir = wd;
              end
            end
            default: b_ctrl = wd;
          endcase
        end
        ppkd_pkg::REQ_KEY: a_value = ppkd_pkg::STROBE | {1'b0, kc};
        default: ;
      endcase
      r.key_ready = a_value[7];
      owed_q.push_back(r);
    endfunction

    function void check_result(logic [7:0] rd, logic dv, logic [7:0] db, logic kr);
      ppkd_pkg::result_t want;
      if (owed_q.size() == 0) begin
        $error("result word with none owed: read_data %0h display_valid %0b", rd, dv);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      if (rd !== want.read_data) begin
        $error("read_data: expected %0h, actual %0h", want.read_data, rd);
        errors++;
      end
      if (dv !== want.display_valid) begin
        $error("display_valid: expected %0b, actual %0b", want.display_valid, dv);
        errors++;
      end
      if (db !== want.display_byte) begin
        $error("display_byte: expected %0h, actual %0h", want.display_byte, db);
        errors++;
      end
      if (kr !== want.key_ready) begin
        $error("key_ready: expected %0b, actual %0b", want.key_ready, kr);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] in_req_type = '0;
  logic [1:0] in_reg_sel = '0;
  logic [7:0] in_write_data = '0;
  logic [6:0] in_kbd_char = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_read_data;
  logic       out_display_valid;
  logic [7:0] out_display_byte;
  logic       out_key_ready;

  port_scoreboard sb;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  logic rx_hold_go = 1'b0;
  int rx_hold_left = 0;

  parallel_port_keyboard_display_top i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_reg_sel       (in_reg_sel),
    .in_write_data    (in_write_data),
    .in_kbd_char      (in_kbd_char),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_display_valid(out_display_valid),
    .out_display_byte (out_display_byte),
    .out_key_ready    (out_key_ready)
  );

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("parallel_port_keyboard_display_top_test: done, errors");
    $finish;
  end

  // result side: check each accepted word, then pick out_ready for the next cycle
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result(out_read_data, out_display_valid, out_display_byte, out_key_ready);
      end
      if (rx_hold_go) rx_hold_left = 150;
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_word(input ppkd_pkg::req_type_t req, input ppkd_pkg::reg_sel_t sel,
                           input logic [7:0] wd, input logic [6:0] kc);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_reg_sel <= sel;
    in_write_data <= wd;
    in_kbd_char <= kc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(req, sel, wd, kc);
  endtask

  task automatic send_random_word();
    int pick;
    ppkd_pkg::req_type_t req;
    pick = $urandom_range(99);
    // mostly reads and writes, keys often enough to keep the strobe busy
    if (pick < 35) req = ppkd_pkg::REQ_READ;
    else if (pick < 70) req = ppkd_pkg::REQ_WRITE;
    else if (pick < 92) req = ppkd_pkg::REQ_KEY;
    else req = ppkd_pkg::REQ_IDLE;
    send_word(req, ppkd_pkg::reg_sel_t'($urandom_range(3)), 8'($urandom_range(255)),
              7'($urandom_range(127)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: registers out of reset, direction mode, then data mode
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_CTRL, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_B_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_B_CTRL, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_A_DATA, 8'hFF, 7'h7F);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_KEY, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h7F);
    // strobe stays set across a direction-mode read
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_A_CTRL, 8'h04, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_KEY, ppkd_pkg::SEL_B_CTRL, 8'hFF, 7'h00);
    send_word(ppkd_pkg::REQ_IDLE, ppkd_pkg::SEL_A_DATA, 8'hFF, 7'h7F);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_A_DATA, 8'h80, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_B_DATA, 8'hAA, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_B_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_B_CTRL, 8'h04, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_B_DATA, 8'h55, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_B_DATA, 8'hFF, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_B_DATA, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_B_CTRL, 8'hFB, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_B_CTRL, 8'h00, 7'h00);
    send_word(ppkd_pkg::REQ_WRITE, ppkd_pkg::SEL_A_CTRL, 8'hFF, 7'h00);
    send_word(ppkd_pkg::REQ_READ, ppkd_pkg::SEL_A_CTRL, 8'h00, 7'h00);

    tx_idle_pct = 27;
    rx_idle_pct = 76;
    repeat (440) send_random_word();

    // long receiver hold while the sender keeps pushing
    tx_idle_pct = 0;
    rx_hold_go <= 1'b1;
    @(posedge clk);
    rx_hold_go <= 1'b0;
    repeat (40) send_random_word();
    wait_drained();

    tx_idle_pct = 76;
    rx_idle_pct = 27;
    repeat (470) send_random_word();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (470) send_random_word();

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("parallel_port_keyboard_display_top_test: done, clean");
    end else begin
      $display("parallel_port_keyboard_display_top_test: done, errors");
    end
    $finish;
  end

endmodule
